FILE: rtl/core/fragment_extent_translator_macros.svh
// Assertion macros used by the translator's sequencer module.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef FRAGMENT_EXTENT_TRANSLATOR_MACROS_SVH
`define FRAGMENT_EXTENT_TRANSLATOR_MACROS_SVH

// Implication checked in the same cycle.
`define FET_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Implication checked in the next cycle.
`define FET_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: rtl/core/fet_pkg.sv
`default_nettype none
package fet_pkg;
	localparam int TableDepth = 32;
	localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
	localparam int CntW = 6;
	localparam int PhysW = 48;
	localparam int LenW = 32;
	localparam int SecW = PhysW + 1;
	localparam int OffW = LenW + IdxW + 1;
	localparam int ReqW = 16;

	localparam logic [1:0] CmdLoad = 2'd0;
	localparam logic [1:0] CmdRead = 2'd1;
	localparam logic [1:0] CmdWrite = 2'd2;
	localparam logic [1:0] CmdNone = 2'd3;

	localparam logic [1:0] StXfer = 2'd0;
	localparam logic [1:0] StZero = 2'd1;
	localparam logic [1:0] StNotFound = 2'd2;

	typedef enum logic [1:0] {
		B_IDLE,
		B_FIND,
		B_MERGE
	} back_state_t;

	typedef struct packed {
		logic [1:0] command;
		logic [5:0] entry_index;
		logic [PhysW-1:0] entry_phys_start;
		logic [LenW-1:0] entry_length;
		logic [PhysW-1:0] req_sector;
		logic [ReqW-1:0] req_count;
	} fet_item_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fet_qctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fet_qstat_t;
endpackage
`default_nettype wire

FILE: rtl/core/fet_front.sv
`default_nettype none
// Front end: takes items, drops the unused command code, and pushes the rest.
module fet_front (
	input wire logic start,
	input wire logic [1:0] command,
	input wire logic [5:0] entry_index,
	input wire logic [47:0] entry_phys_start,
	input wire logic [31:0] entry_length,
	input wire logic [47:0] req_sector,
	input wire logic [15:0] req_count,
	input wire fet_pkg::fet_qstat_t qstat,
	output logic busy,
	output logic push,
	output fet_pkg::fet_item_t item
);
	always_comb begin
		busy = qstat.full;
		push = start && !qstat.full && (command != fet_pkg::CmdNone);
		item.command = command;
		item.entry_index = entry_index;
		item.entry_phys_start = entry_phys_start;
		item.entry_length = entry_length;
		item.req_sector = req_sector;
		item.req_count = req_count;
	end
endmodule
`default_nettype wire

FILE: rtl/core/fet_queue.sv
`default_nettype none
// Two-entry queue between the front end and the sequencer.
module fet_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire fet_pkg::fet_qctl_t qctl,
	input wire fet_pkg::fet_item_t wr_item,
	output fet_pkg::fet_item_t rd_item,
	output fet_pkg::fet_qstat_t qstat
);
	fet_pkg::fet_item_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (qctl.push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (qctl.push) wr_ptr_q <= ~wr_ptr_q;
			if (qctl.pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, qctl.push} - {1'b0, qctl.pop};
		end
	end

	always_comb begin
		rd_item = mem_q[rd_ptr_q];
		qstat.empty = (count_q == 2'd0);
		qstat.full = (count_q == 2'd2);
	end
endmodule
`default_nettype wire

FILE: rtl/core/fet_back.sv
`default_nettype none
`include "fragment_extent_translator_macros.svh"
// Sequencer: holds the fragment table and walks it one entry per cycle.
module fet_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [5:0] cfg_wdata,
	input wire fet_pkg::fet_item_t head,
	input wire logic head_valid,
	output logic pop,
	output logic strobe,
	output logic [1:0] status,
	output logic is_write,
	output logic [47:0] phys_sector,
	output logic [15:0] xfer_count,
	output logic [15:0] buffer_offset,
	output logic last
);
	localparam int IdxW = fet_pkg::IdxW;
	localparam int OffW = fet_pkg::OffW;
	localparam int SecW = fet_pkg::SecW;
	localparam int PhysW = fet_pkg::PhysW;
	localparam int LenW = fet_pkg::LenW;
	localparam int ReqW = fet_pkg::ReqW;
	localparam int CntW = fet_pkg::CntW;
	localparam logic [CntW-1:0] Depth = CntW'(fet_pkg::TableDepth);

	logic [PhysW-1:0] phys_q [fet_pkg::TableDepth];
	logic [LenW-1:0] len_q [fet_pkg::TableDepth];

	fet_pkg::back_state_t state_q, state_d;
	logic [CntW-1:0] frag_count_q;
	logic cur_valid_q;
	logic [IdxW-1:0] cur_frag_q;
	logic [PhysW-1:0] cur_off_q;

	logic is_read_q;
	logic [SecW-1:0] sector_q;
	logic [ReqW-1:0] left_q, done_q;
	logic [CntW-1:0] idx_q, lf_q;
	logic [OffW-1:0] off_q, lbase_q, avail_q;
	logic [LenW-1:0] llen_q;
	logic [PhysW-1:0] pend_q, pout_q;

	logic [CntW-1:0] used_n, nx, rd_idx;
	logic [PhysW-1:0] rd_phys;
	logic [LenW-1:0] rd_len;
	logic [SecW-1:0] off_ext, end_ext;
	logic hit, at_end, merge_ok, cur_ok, is_req;
	logic [ReqW-1:0] take;

	assign used_n = (frag_count_q > Depth) ? Depth : frag_count_q;
	assign nx = lf_q + CntW'(1);
	assign rd_idx = (state_q == fet_pkg::B_MERGE) ? nx : idx_q;
	assign rd_phys = phys_q[rd_idx[IdxW-1:0]];
	assign rd_len = len_q[rd_idx[IdxW-1:0]];
	assign off_ext = SecW'(off_q);
	assign end_ext = SecW'(off_q) + SecW'(rd_len);
	assign at_end = (idx_q >= used_n);
	assign hit = !at_end && (off_ext <= sector_q) && (sector_q < end_ext);
	assign merge_ok = is_read_q && (avail_q < OffW'(left_q)) && (nx < used_n)
		&& (rd_len != '0) && (rd_phys == pend_q);
	assign take = (OffW'(left_q) < avail_q) ? left_q : avail_q[ReqW-1:0];
	assign is_req = (head.command == fet_pkg::CmdRead)
		|| (head.command == fet_pkg::CmdWrite);
	assign cur_ok = cur_valid_q && (CntW'(cur_frag_q) < used_n)
		&& (cur_off_q <= head.req_sector);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fet_pkg::B_IDLE: begin
				if (head_valid && is_req && (head.req_count != '0)) begin
					state_d = fet_pkg::B_FIND;
				end
			end
			fet_pkg::B_FIND: begin
				if (at_end) state_d = fet_pkg::B_IDLE;
				else if (hit) state_d = fet_pkg::B_MERGE;
			end
			fet_pkg::B_MERGE: begin
				if (!merge_ok && (take == left_q)) state_d = fet_pkg::B_IDLE;
				else if (!merge_ok) state_d = fet_pkg::B_FIND;
			end
			default: state_d = fet_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop = (state_q == fet_pkg::B_IDLE) && head_valid;
	end

	always_ff @(posedge clk) begin
		if (pop && (head.command == fet_pkg::CmdLoad)
			&& (head.entry_index < Depth)) begin
			phys_q[head.entry_index[IdxW-1:0]] <= head.entry_phys_start;
			len_q[head.entry_index[IdxW-1:0]] <= head.entry_length;
		end
		unique case (state_q)
			fet_pkg::B_IDLE: begin
				is_read_q <= (head.command == fet_pkg::CmdRead);
				sector_q <= SecW'(head.req_sector);
				left_q <= head.req_count;
				done_q <= '0;
				if ((head.command == fet_pkg::CmdRead) && cur_ok) begin
					idx_q <= CntW'(cur_frag_q);
					off_q <= cur_off_q[OffW-1:0];
				end else begin
					idx_q <= '0;
					off_q <= '0;
				end
			end
			fet_pkg::B_FIND: begin
				if (hit) begin
					lf_q <= idx_q;
					lbase_q <= off_q;
					llen_q <= rd_len;
					avail_q <= OffW'(end_ext - sector_q);
					pend_q <= rd_phys + PhysW'(rd_len);
					pout_q <= rd_phys + PhysW'(sector_q - off_ext);
				end else begin
					off_q <= off_q + OffW'(rd_len);
					idx_q <= idx_q + CntW'(1);
				end
			end
			fet_pkg::B_MERGE: begin
				if (merge_ok) begin
					lbase_q <= lbase_q + OffW'(llen_q);
					llen_q <= rd_len;
					avail_q <= avail_q + OffW'(rd_len);
					pend_q <= pend_q + PhysW'(rd_len);
					lf_q <= nx;
				end else begin
					left_q <= left_q - take;
					done_q <= done_q + take;
					sector_q <= sector_q + SecW'(take);
					idx_q <= lf_q;
					off_q <= lbase_q;
				end
			end
			default: ;
		endcase
		if (state_q == fet_pkg::B_IDLE) begin
			status <= fet_pkg::StZero;
			is_write <= (head.command == fet_pkg::CmdWrite);
			phys_sector <= '0;
			xfer_count <= '0;
			buffer_offset <= '0;
			last <= 1'b1;
		end else if (state_q == fet_pkg::B_FIND) begin
			status <= fet_pkg::StNotFound;
			is_write <= !is_read_q;
			phys_sector <= '0;
			xfer_count <= '0;
			buffer_offset <= done_q;
			last <= 1'b1;
		end else begin
			status <= fet_pkg::StXfer;
			is_write <= !is_read_q;
			phys_sector <= pout_q;
			xfer_count <= take;
			buffer_offset <= done_q;
			last <= (take == left_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fet_pkg::B_IDLE;
			frag_count_q <= '0;
			cur_valid_q <= 1'b0;
			cur_frag_q <= '0;
			cur_off_q <= '0;
			strobe <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe <= (pop && is_req && (head.req_count == '0))
				|| ((state_q == fet_pkg::B_FIND) && at_end)
				|| ((state_q == fet_pkg::B_MERGE) && !merge_ok);
			if (cfg_we) begin
				frag_count_q <= cfg_wdata;
				cur_valid_q <= 1'b0;
			end else if (pop && (head.command == fet_pkg::CmdLoad)) begin
				cur_valid_q <= 1'b0;
			end else if ((state_q == fet_pkg::B_FIND) && at_end && is_read_q) begin
				cur_valid_q <= 1'b0;
			end else if ((state_q == fet_pkg::B_MERGE) && !merge_ok && is_read_q) begin
				cur_valid_q <= 1'b1;
				cur_frag_q <= lf_q[IdxW-1:0];
				cur_off_q <= PhysW'(lbase_q);
			end
		end
	end

	`FET_ASSERT_SAME(a_ctl_last, strobe && status != fet_pkg::StXfer, last, "no last flag")
	`FET_ASSERT_SAME(a_xfer_nz, strobe && status == fet_pkg::StXfer, xfer_count != '0, "zero transfer")
	`FET_ASSERT_SAME(a_walk_bound, state_q == fet_pkg::B_FIND, idx_q <= used_n, "walk beyond table")
	`FET_ASSERT_NEXT(a_pop_idle, pop, $past(state_q) == fet_pkg::B_IDLE, "pop while sequencer busy")
endmodule
`default_nettype wire

FILE: rtl/core/fragment_extent_translator.sv
`default_nettype none
// Fragment extent translator. An item is taken at a clock edge where start is high and busy is
// low; a two-entry queue absorbs items while the sequencer works, and busy rises only when it is
// full. A load item or a zero-count request is handled as it leaves the queue. Any other
// request leaves the queue, then the table entries are examined in turn, merged contiguous
// fragments are gathered and transfer commands are issued. After a command that used up its
// fragment the search resumes at that same fragment, so it is examined again before the walk
// moves on. Reads start from the cursor when their sector lies at or beyond the start of the
// last fragment reached. Results appear on the result ports for exactly one cycle with strobe
// high; the receiver cannot stall them, so it must take every strobed result as it comes. The
// user must write the fragment_count register through cfg_we and cfg_wdata only while no item
// is in flight; the block itself does not enforce this.
module fragment_extent_translator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [5:0] cfg_wdata,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] command,
	input wire logic [5:0] entry_index,
	input wire logic [47:0] entry_phys_start,
	input wire logic [31:0] entry_length,
	input wire logic [47:0] req_sector,
	input wire logic [15:0] req_count,
	output logic strobe,
	output logic [1:0] status,
	output logic is_write,
	output logic [47:0] phys_sector,
	output logic [15:0] xfer_count,
	output logic [15:0] buffer_offset,
	output logic last
);
	// Queue control and status travel as small structs between the parts.
	fet_pkg::fet_item_t in_item, head_item;
	fet_pkg::fet_qctl_t qctl;
	fet_pkg::fet_qstat_t qstat;
	logic push, pop;

	assign qctl.push = push;
	assign qctl.pop = pop;

	fet_front u_front (
		.start(start),
		.command(command),
		.entry_index(entry_index),
		.entry_phys_start(entry_phys_start),
		.entry_length(entry_length),
		.req_sector(req_sector),
		.req_count(req_count),
		.qstat(qstat),
		.busy(busy),
		.push(push),
		.item(in_item)
	);

	fet_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.qctl(qctl),
		.wr_item(in_item),
		.rd_item(head_item),
		.qstat(qstat)
	);

	// The sequencer owns the table, the cursor and the result registers.
	fet_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.head(head_item),
		.head_valid(!qstat.empty),
		.pop(pop),
		.strobe(strobe),
		.status(status),
		.is_write(is_write),
		.phys_sector(phys_sector),
		.xfer_count(xfer_count),
		.buffer_offset(buffer_offset),
		.last(last)
	);
endmodule
`default_nettype wire

FILE: tb/sv/fragment_extent_checker.sv
`default_nettype none
module fragment_extent_checker
	import fet_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [5:0] cfg_wdata,
	input wire logic start,
	input wire logic busy,
	input wire logic [1:0] command,
	input wire logic [5:0] entry_index,
	input wire logic [47:0] entry_phys_start,
	input wire logic [31:0] entry_length,
	input wire logic [47:0] req_sector,
	input wire logic [15:0] req_count,
	input wire logic strobe,
	input wire logic [1:0] status,
	input wire logic is_write,
	input wire logic [47:0] phys_sector,
	input wire logic [15:0] xfer_count,
	input wire logic [15:0] buffer_offset,
	input wire logic last,
	output int fail_count,
	output int outstanding
);
	localparam longint unsigned Mask48 = 64'h0000_FFFF_FFFF_FFFF;

	typedef struct {
		logic [1:0] status;
		logic is_write;
		logic [47:0] phys;
		logic [15:0] count;
		logic [15:0] offset;
		logic last;
	} transfer_t;

	transfer_t transfer_q[$];
	longint unsigned frag_start[TableDepth];
	longint unsigned frag_len[TableDepth];
	logic [5:0] used_regs;
	bit cur_valid;
	int unsigned cur_frag;
	longint unsigned cur_base;

	task automatic push_transfer(logic [1:0] st, logic wr, longint unsigned ps,
			longint unsigned cnt, longint unsigned off, logic lst);
		transfer_t t;
		t.status = st;
		t.is_write = wr;
		t.phys = ps[47:0];
		t.count = cnt[15:0];
		t.offset = off[15:0];
		t.last = lst;
		transfer_q.push_back(t);
	endtask

	// Locates the fragment holding a logical sector; reads may resume at the cursor.
	task automatic locate(longint unsigned sector, int unsigned n, bit use_cursor,
			output bit found, output int unsigned frag, output longint unsigned base);
		int unsigned i;
		longint unsigned off;
		i = 0;
		off = 0;
		found = 0;
		frag = 0;
		base = 0;
		if (use_cursor && cur_valid && cur_frag < n && cur_base <= sector) begin
			i = cur_frag;
			off = cur_base;
			if (sector < off + frag_len[i]) begin
				found = 1;
				frag = i;
				base = off;
				return;
			end
			off += frag_len[i];
			i++;
		end
		for (; i < n; i++) begin
			if (off <= sector && sector < off + frag_len[i]) begin
				found = 1;
				frag = i;
				base = off;
				return;
			end
			off += frag_len[i];
		end
	endtask

	task automatic translate(logic wr, longint unsigned sector, int unsigned left);
		int unsigned n, k, f, lf, nx;
		longint unsigned done, base, lbase, avail, pend, take;
		bit found;
		n = (used_regs > TableDepth) ? TableDepth : used_regs;
		k = 0;
		done = 0;
		if (left == 0) begin
			push_transfer(StZero, wr, 0, 0, 0, 1'b1);
			return;
		end
		while (left > 0 && k < 63) begin
			locate(sector, n, !wr, found, f, base);
			if (!found) begin
				if (!wr)
					cur_valid = 0;
				push_transfer(StNotFound, wr, 0, 0, done, 1'b1);
				return;
			end
			avail = base + frag_len[f] - sector;
			lf = f;
			lbase = base;
			if (!wr) begin
				// Reads run on through following fragments that continue physically.
				pend = (frag_start[f] + frag_len[f]) & Mask48;
				while (avail < left && lf + 1 < n) begin
					nx = lf + 1;
					if (frag_len[nx] == 0 || frag_start[nx] != pend)
						break;
					lbase += frag_len[lf];
					avail += frag_len[nx];
					pend = (pend + frag_len[nx]) & Mask48;
					lf = nx;
				end
			end
			take = (left < avail) ? left : avail;
			left -= int'(take);
			push_transfer(StXfer, wr, (frag_start[f] + (sector - base)) & Mask48, take, done,
				left == 0);
			k++;
			if (!wr) begin
				cur_valid = 1;
				cur_frag = lf;
				cur_base = lbase & Mask48;
			end
			sector += take;
			done += take;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transfer_q.delete();
			for (int i = 0; i < TableDepth; i++) begin
				frag_start[i] = 0;
				frag_len[i] = 0;
			end
			used_regs = 0;
			cur_valid = 0;
			cur_frag = 0;
			cur_base = 0;
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (strobe) begin
				if (transfer_q.size() == 0) begin
					$error("result with nothing expected: status %0d", status);
					fail_count++;
				end else begin
					transfer_t e;
					e = transfer_q.pop_front();
					if (status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, status);
						fail_count++;
					end
					if (is_write !== e.is_write) begin
						$error("is_write: expected %0d, got %0d", e.is_write, is_write);
						fail_count++;
					end
					if (phys_sector !== e.phys) begin
						$error("phys_sector: expected %0h, got %0h", e.phys, phys_sector);
						fail_count++;
					end
					if (xfer_count !== e.count) begin
						$error("xfer_count: expected %0d, got %0d", e.count, xfer_count);
						fail_count++;
					end
					if (buffer_offset !== e.offset) begin
						$error("buffer_offset: expected %0d, got %0d", e.offset, buffer_offset);
						fail_count++;
					end
					if (last !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, last);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				used_regs = cfg_wdata;
				cur_valid = 0;
			end
			if (start && !busy) begin
				case (command)
					CmdLoad: begin
						if (entry_index < TableDepth) begin
							frag_start[entry_index] = entry_phys_start;
							frag_len[entry_index] = entry_length;
						end
						cur_valid = 0;
					end
					CmdRead: translate(1'b0, req_sector, req_count);
					CmdWrite: translate(1'b1, req_sector, req_count);
					default: ;
				endcase
			end
			outstanding = transfer_q.size();
		end
	end
endmodule
`default_nettype wire

FILE: tb/sv/fragment_extent_translator_test.sv
`default_nettype none
module fragment_extent_translator_test;
	import fet_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [5:0] cfg_wdata = '0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] command = CmdNone;
	logic [5:0] entry_index = '0;
	logic [47:0] entry_phys_start = '0;
	logic [31:0] entry_length = '0;
	logic [47:0] req_sector = '0;
	logic [15:0] req_count = '0;
	logic strobe;
	logic [1:0] status;
	logic is_write;
	logic [47:0] phys_sector;
	logic [15:0] xfer_count;
	logic [15:0] buffer_offset;
	logic last;
	int fail_count;
	int outstanding;

	// The stimulus keeps its own copy of fragment lengths and the register so that
	// request sectors can be aimed inside, at the end of, or beyond the mapped range.
	longint unsigned frag_len[TableDepth];
	int unsigned used_regs;
	longint unsigned next_sector;
	bit idling;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	fragment_extent_translator uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .command(command), .entry_index(entry_index),
		.entry_phys_start(entry_phys_start), .entry_length(entry_length),
		.req_sector(req_sector), .req_count(req_count), .strobe(strobe),
		.status(status), .is_write(is_write), .phys_sector(phys_sector),
		.xfer_count(xfer_count), .buffer_offset(buffer_offset), .last(last)
	);

	fragment_extent_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .command(command), .entry_index(entry_index),
		.entry_phys_start(entry_phys_start), .entry_length(entry_length),
		.req_sector(req_sector), .req_count(req_count), .strobe(strobe),
		.status(status), .is_write(is_write), .phys_sector(phys_sector),
		.xfer_count(xfer_count), .buffer_offset(buffer_offset), .last(last),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	// Presents one item and returns at the edge that accepts it. It is always called
	// right after a rising edge; the busy value read there is the one the edge saw.
	task automatic send_item(logic [1:0] cmd, logic [5:0] idx, logic [47:0] ps,
			logic [31:0] len, logic [47:0] sector, logic [15:0] cnt);
		start <= 1'b1;
		command <= cmd;
		entry_index <= idx;
		entry_phys_start <= ps;
		entry_length <= len;
		req_sector <= sector;
		req_count <= cnt;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (cmd == CmdLoad && idx < TableDepth)
			frag_len[idx] = len;
		if (cmd == CmdRead || cmd == CmdWrite)
			next_sector = sector + cnt;
	endtask

	// Between items the sender sometimes goes quiet for a random burst of cycles.
	task automatic sender_gap();
		if (idling && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13))
				@(posedge clk);
		end
	endtask

	// Stops sending and waits until every expected result has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Loads can still sit in the queue after the last result, so the register is
	// written only after a further pause that outlasts them by far.
	task automatic write_fragment_count(logic [5:0] value);
		drain();
		repeat (80)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		used_regs = value;
	endtask

	function automatic logic [47:0] random48();
		return 48'({$urandom(), $urandom()});
	endfunction

	// Rewrites every slot. About half the fragments continue the previous one
	// physically so that reads merge; some are empty and a few are huge.
	task automatic load_table();
		logic [47:0] ps;
		logic [31:0] len;
		longint unsigned pend;
		pend = random48();
		for (int i = 0; i < TableDepth; i++) begin
			case ($urandom_range(0, 19))
				0, 1: len = 0;
				2: len = $urandom();
				default: len = $urandom_range(1, 9);
			endcase
			ps = ($urandom_range(0, 1) == 0) ? pend[47:0] : random48();
			send_item(CmdLoad, 6'(i), ps, len, random48(), 16'($urandom()));
			pend = ps + len;
			sender_gap();
		end
	endtask

	function automatic longint unsigned mapped_total();
		longint unsigned total;
		int unsigned n;
		total = 0;
		n = (used_regs > TableDepth) ? TableDepth : used_regs;
		for (int i = 0; i < n; i++)
			total += frag_len[i];
		return total;
	endfunction

	task automatic random_request();
		logic [1:0] cmd;
		logic [47:0] sector;
		logic [15:0] cnt;
		longint unsigned total;
		total = mapped_total();
		cmd = ($urandom_range(0, 9) < 6) ? CmdRead : CmdWrite;
		case ($urandom_range(0, 9))
			0: sector = random48();
			1: sector = total[47:0] + $urandom_range(0, 3);
			2, 3: sector = next_sector[47:0];
			default: sector = (total == 0) ? 48'd0 : 48'({random48()} % total);
		endcase
		case ($urandom_range(0, 19))
			0: cnt = 0;
			1: cnt = 16'($urandom());
			default: cnt = 16'($urandom_range(1, 40));
		endcase
		// Now and then an item with the unused command code or a stray load slips in.
		case ($urandom_range(0, 29))
			0: send_item(CmdNone, 6'($urandom()), random48(), $urandom(), sector, cnt);
			1: send_item(CmdLoad, 6'($urandom_range(TableDepth, 63)), random48(),
				$urandom(), sector, cnt);
			default: send_item(cmd, 6'($urandom()), random48(), $urandom(), sector, cnt);
		endcase
	endtask

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		idling = 1'b1;
		next_sector = 0;
		used_regs = 0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_fragment_count(6'd32);
		load_table();
		// A fragment that wraps past the top of the physical space, with the next one
		// continuing at 2, then an empty fragment that must stop the merge.
		send_item(CmdLoad, 6'd0, 48'hFFFF_FFFF_FFFE, 32'd4, '0, '0);
		send_item(CmdLoad, 6'd1, 48'd2, 32'd5, '0, '0);
		send_item(CmdLoad, 6'd2, 48'd7, 32'd0, '0, '0);
		send_item(CmdLoad, 6'd3, 48'd7, 32'd3, '0, '0);
		send_item(CmdLoad, 6'd31, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
		send_item(CmdLoad, 6'd63, 48'h1234, 32'd9, '0, '0);
		send_item(CmdLoad, 6'd40, 48'h5678, 32'd9, '0, '0);
		send_item(CmdRead, '0, '0, '0, 48'd0, 16'd20);
		send_item(CmdWrite, '0, '0, '0, 48'd0, 16'd20);
		send_item(CmdRead, '0, '0, '0, 48'd3, 16'd0);
		send_item(CmdWrite, '0, '0, '0, 48'd3, 16'd0);
		send_item(CmdRead, '0, '0, '0, 48'hFFFF_FFFF_FFFF, 16'd1);
		send_item(CmdWrite, '0, '0, '0, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
		send_item(CmdRead, '0, '0, '0, 48'd0, 16'hFFFF);
		send_item(CmdNone, 6'h3F, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 48'd5, 16'd5);
		// Sequential reads that should pick up at the cursor.
		send_item(CmdRead, '0, '0, '0, 48'd1, 16'd3);
		send_item(CmdRead, '0, '0, '0, 48'd4, 16'd5);
		send_item(CmdRead, '0, '0, '0, 48'd9, 16'd2);
		write_fragment_count(6'd0);
		send_item(CmdRead, '0, '0, '0, 48'd0, 16'd1);
		write_fragment_count(6'd63);
		send_item(CmdRead, '0, '0, '0, 48'd2, 16'd30);

		for (int phase = 0; phase < 6; phase++) begin
			idling = (phase < 5);
			case (phase)
				0: write_fragment_count(6'd63);
				1: write_fragment_count(6'd1);
				2: write_fragment_count(6'd32);
				3: write_fragment_count(6'd31);
				default: write_fragment_count(6'($urandom_range(0, 63)));
			endcase
			if (phase == 3)
				load_table();
			for (int i = 0; i < 8; i++) begin
				random_request();
				if (phase == 2 && i == 4)
					drain();
				else
					sender_gap();
			end
		end

		drain();
		repeat (100)
			@(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

FILE: fragment_extent_translator.f
+incdir+rtl/core
rtl/core/fet_pkg.sv
rtl/core/fet_front.sv
rtl/core/fet_queue.sv
rtl/core/fet_back.sv
rtl/core/fragment_extent_translator.sv
tb/sv/fragment_extent_checker.sv
tb/sv/fragment_extent_translator_test.sv
